// ----- rtl/core/cfa_pkg.sv -----
// Shared constants, action codes and helpers for the GF(2^255-19) field unit.
package cfa_pkg;

	localparam int REG_COUNT     = 8;
	localparam int REG_AW        = $clog2(REG_COUNT);
	localparam int LIMBS         = 16;
	localparam int LIMB_W        = 16;
	localparam int RF_DEPTH      = REG_COUNT * LIMBS;
	localparam int RF_AW         = $clog2(RF_DEPTH);
	localparam int SCR_AW        = $clog2(LIMBS);
	localparam int COL_W         = 36;
	localparam int WIDE_W        = 48;
	localparam int FOLD_WIDE     = 38;
	localparam int FOLD_LOW      = 19;
	localparam logic [LIMB_W-1:0] TOP_LIMB_MASK = 16'h7FFF;
	localparam logic [LIMB_W-1:0] TWOP_LOW      = 16'hFFDA;
	localparam logic [LIMB_W-1:0] TWOP_LIMB     = 16'hFFFF;
	localparam logic [7:0] INV_TOP_BIT = 8'd253;
	localparam logic [7:0] INV_SKIP_LO = 8'd2;
	localparam logic [7:0] INV_SKIP_HI = 8'd4;

	localparam int SELW      = (REG_AW > 3) ? REG_AW : 3;
	localparam int SELW_P1   = SELW + 1;
	localparam int SEL_STEPS = 4;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_ADD   = 3'd2,
		ACT_SUB   = 3'd3,
		ACT_MUL   = 3'd4,
		ACT_INV   = 3'd5,
		ACT_SWAP  = 3'd6,
		ACT_NOP   = 3'd7
	} act_t;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [COL_W-1:0] col_t;

	// Register numbers wrap around the file size.
	function automatic logic [REG_AW-1:0] reg_sel(input logic [2:0] r);
		logic [SELW:0] v;
		v = {{(SELW-2){1'b0}}, r};
		for (int k = 0; k < SEL_STEPS; k++) begin
			if (v >= SELW_P1'(REG_COUNT)) v = v - SELW_P1'(REG_COUNT);
		end
		return v[REG_AW-1:0];
	endfunction

endpackage

// ----- rtl/core/cfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/curve25519_field_alu.sv -----
// Write limb, no-op and a swap without the bit go straight to the completion state; the other
// actions stream their operands out of the register file. Inversion runs 254 squarings and
// 252 multiplies. The register-file RAM port moves one limb per cycle, and the three carry
// passes and the final subtraction of p also run one limb per cycle.
// One item is in work at a time, and the next transfer is taken once the result is in the
// output register. Reset clears control state and the per-limb valid bits, so the file reads
// as zero.
module curve25519_field_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], dst_reg[5:3], src_a[8:6], src_b[11:9], limb_index[15:12],
	// limb_value[31:16], swap_bit[32], zero fill above
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_value[15:0], done_action[18:16], zero fill above
	output logic [23:0] m_tdata
);
	import cfa_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_LOAD  = 10'b0000000010,
		ST_MUL   = 10'b0000000100,
		ST_FOLD  = 10'b0000001000,
		ST_PREP  = 10'b0000010000,
		ST_CARRY = 10'b0000100000,
		ST_FINAL = 10'b0001000000,
		ST_WB    = 10'b0010000000,
		ST_SWAP  = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;
	logic [1:0] pass_q;
	logic ld_ph_q;
	logic [7:0] bit_q;
	logic sq_q, first_q;
	logic out_valid_q;

	act_t act_q;
	logic [REG_AW-1:0] dst_q, ra_q, rb_q;
	logic [3:0] limb_q;
	limb_t rv_q, out_rv_q;
	act_t out_act_q;
	logic bor_q, t_sel_q;

	limb_t opa_q [LIMBS];
	limb_t opb_q [LIMBS];
	limb_t t_q [LIMBS];
	wide_t w_q [LIMBS];
	col_t col_q [LIMBS];
	wide_t c_q, cy_q;

	act_t in_act;
	logic accept, out_fire;
	logic ld_src_scr, ld_tgt_a, ld_tgt_b, ld_last;
	logic [REG_AW-1:0] ld_reg;
	logic inv_final, wb_to_rf, wb_to_scr;
	limb_t ld_data, r_limb, sub_d, in_value;
	logic [16:0] sub_x;
	wide_t prep_w, carry_v, fin_we, fin_tv;
	col_t mul_sum [LIMBS];

	logic rf_we, rf_re, scr_we, scr_re, rf_vld_s1;
	logic [RF_AW-1:0] rf_waddr, rf_raddr;
	limb_t rf_wdata, rf_rdata, scr_rdata;
	logic rf_vld_q [RF_DEPTH];

	assign in_act   = act_t'(s_tdata[2:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_fire = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_act_q, out_rv_q};

	// Source and target of the element being streamed out of memory.
	always_comb begin
		ld_src_scr = 1'b0;
		ld_tgt_a   = 1'b1;
		ld_tgt_b   = 1'b0;
		ld_reg     = ra_q;
		ld_last    = 1'b0;
		unique case (act_q)
			ACT_INV: begin
				if (sq_q) begin
					ld_src_scr = !first_q;
					ld_tgt_b   = 1'b1;
					ld_last    = 1'b1;
				end else if (!ld_ph_q) begin
					ld_src_scr = 1'b1;
				end else begin
					ld_tgt_a = 1'b0;
					ld_tgt_b = 1'b1;
					ld_last  = 1'b1;
				end
			end
			ACT_READ: begin
				ld_last = 1'b1;
			end
			default: begin
				if (ld_ph_q) begin
					ld_tgt_a = 1'b0;
					ld_tgt_b = 1'b1;
					ld_reg   = rb_q;
					ld_last  = 1'b1;
				end
			end
		endcase
	end

	assign inv_final = !sq_q && (bit_q == 8'd0);
	assign wb_to_scr = (act_q == ACT_INV) && !inv_final;
	assign wb_to_rf  = !wb_to_scr && (act_q != ACT_READ);

	assign ld_data = ld_src_scr ? scr_rdata : (rf_vld_s1 ? rf_rdata : '0);

	// Subtraction adds 2p - b, formed limb by limb with a running borrow.
	assign sub_x  = 17'h10000 + {1'b0, (cnt_q == 5'd0) ? TWOP_LOW : TWOP_LIMB}
		- {1'b0, opb_q[0]} - {16'd0, bor_q};
	assign sub_d  = sub_x[15:0];
	always_comb begin
		unique case (act_q)
			ACT_READ: prep_w = WIDE_W'(opa_q[0]);
			ACT_ADD:  prep_w = WIDE_W'(opa_q[0]) + WIDE_W'(opb_q[0]);
			default:  prep_w = WIDE_W'(opa_q[0]) + WIDE_W'(sub_d);
		endcase
	end

	always_comb begin
		for (int j = 0; j < LIMBS; j++) begin
			mul_sum[j] = col_q[j] + COL_W'(32'(opa_q[0]) * 32'(opb_q[j]));
		end
	end

	assign carry_v = w_q[0] + c_q;
	assign fin_we  = w_q[0] + ((cnt_q == 5'd0) ? c_q : '0);
	assign fin_tv  = fin_we + cy_q;

	always_comb begin
		if (t_sel_q) r_limb = (cnt_q == 5'd15) ? (t_q[0] & TOP_LIMB_MASK) : t_q[0];
		else r_limb = w_q[0][15:0];
	end

	assign in_value = (s_tdata[15:12] == 4'd15) ? (s_tdata[31:16] & TOP_LIMB_MASK)
		: s_tdata[31:16];

	// Memory ports.
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = {ra_q, cnt_q[3:0]};
		rf_wdata = r_limb;
		if (accept && in_act == ACT_WRITE) begin
			rf_we    = 1'b1;
			rf_waddr = {reg_sel(s_tdata[5:3]), s_tdata[15:12]};
			rf_wdata = in_value;
		end else if (state_q == ST_WB && wb_to_rf) begin
			rf_we    = 1'b1;
			rf_waddr = {dst_q, cnt_q[3:0]};
		end else if (state_q == ST_SWAP) begin
			rf_we    = 1'b1;
			rf_waddr = cnt_q[4] ? {rb_q, cnt_q[3:0]} : {ra_q, cnt_q[3:0]};
			rf_wdata = cnt_q[4] ? opa_q[0] : opb_q[0];
		end
	end

	assign rf_re    = (state_q == ST_LOAD) && !cnt_q[4] && !ld_src_scr;
	assign rf_raddr = {ld_reg, cnt_q[3:0]};
	assign scr_re   = (state_q == ST_LOAD) && !cnt_q[4] && ld_src_scr;
	assign scr_we   = (state_q == ST_WB) && wb_to_scr;

	cfa_ram #(.WIDTH(LIMB_W), .DEPTH(RF_DEPTH)) u_rf_ram (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rf_re),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	cfa_ram #(.WIDTH(LIMB_W), .DEPTH(LIMBS)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (cnt_q[SCR_AW-1:0]),
		.wdata (r_limb),
		.re    (scr_re),
		.raddr (cnt_q[SCR_AW-1:0]),
		.rdata (scr_rdata)
	);

	// A limb that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RF_DEPTH; i++) rf_vld_q[i] <= 1'b0;
			rf_vld_s1 <= 1'b0;
		end else begin
			if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
			if (rf_re) rf_vld_s1 <= rf_vld_q[rf_raddr];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pass_q      <= '0;
			ld_ph_q     <= 1'b0;
			bit_q       <= '0;
			sq_q        <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						ld_ph_q <= 1'b0;
						bit_q   <= INV_TOP_BIT;
						sq_q    <= 1'b1;
						first_q <= 1'b1;
						case (in_act) inside
							ACT_READ, ACT_ADD, ACT_SUB, ACT_MUL, ACT_INV: state_q <= ST_LOAD;
							ACT_SWAP: state_q <= s_tdata[32] ? ST_LOAD : ST_DONE;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOAD: begin
					if (cnt_q == 5'd16) begin
						cnt_q <= '0;
						if (!ld_last) begin
							ld_ph_q <= 1'b1;
						end else begin
							case (act_q) inside
								ACT_MUL, ACT_INV: state_q <= ST_MUL;
								ACT_SWAP:         state_q <= ST_SWAP;
								default:          state_q <= ST_PREP;
							endcase
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MUL: begin
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						state_q <= ST_FOLD;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_FOLD: begin
					pass_q  <= '0;
					state_q <= ST_CARRY;
				end
				ST_PREP: begin
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						pass_q  <= '0;
						state_q <= ST_CARRY;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_CARRY: begin
					if (cnt_q == 5'd15) begin
						cnt_q  <= '0;
						pass_q <= pass_q + 2'd1;
						if (pass_q == 2'd2) state_q <= ST_FINAL;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_FINAL: begin
					if (cnt_q == 5'd15) begin
						cnt_q   <= '0;
						state_q <= ST_WB;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_WB: begin
					if (cnt_q == 5'd15) begin
						cnt_q <= '0;
						if (wb_to_scr) begin
							// Step the exponent: square every bit, multiply where the bit is set.
							state_q <= ST_LOAD;
							ld_ph_q <= 1'b0;
							first_q <= 1'b0;
							if (sq_q && bit_q != INV_SKIP_LO && bit_q != INV_SKIP_HI) begin
								sq_q <= 1'b0;
							end else begin
								sq_q  <= 1'b1;
								bit_q <= bit_q - 8'd1;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SWAP: begin
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_act;
			dst_q  <= reg_sel(s_tdata[5:3]);
			ra_q   <= reg_sel(s_tdata[8:6]);
			rb_q   <= reg_sel(s_tdata[11:9]);
			limb_q <= s_tdata[15:12];
			rv_q   <= '0;
		end
		if (out_fire) begin
			out_rv_q  <= rv_q;
			out_act_q <= act_q;
		end
		unique case (state_q)
			ST_LOAD: begin
				bor_q <= 1'b0;
				for (int j = 0; j < LIMBS; j++) col_q[j] <= '0;
				if (cnt_q != 5'd0) begin
					if (ld_tgt_a) begin
						for (int k = 0; k < LIMBS - 1; k++) opa_q[k] <= opa_q[k+1];
						opa_q[LIMBS-1] <= ld_data;
					end
					if (ld_tgt_b) begin
						for (int k = 0; k < LIMBS - 1; k++) opb_q[k] <= opb_q[k+1];
						opb_q[LIMBS-1] <= ld_data;
					end
				end
			end
			ST_MUL: begin
				// Column cnt is complete after this row and leaves the window.
				for (int k = 0; k < LIMBS - 1; k++) begin
					opa_q[k] <= opa_q[k+1];
					w_q[k]   <= w_q[k+1];
					col_q[k] <= mul_sum[k+1];
				end
				opa_q[LIMBS-1] <= opa_q[0];
				w_q[LIMBS-1]   <= WIDE_W'(mul_sum[0]);
				col_q[LIMBS-1] <= '0;
			end
			ST_FOLD: begin
				c_q <= '0;
				for (int k = 0; k < LIMBS - 1; k++) begin
					w_q[k] <= w_q[k] + WIDE_W'(col_q[k]) * WIDE_W'(FOLD_WIDE);
				end
			end
			ST_PREP: begin
				c_q   <= '0;
				bor_q <= ~sub_x[16];
				for (int k = 0; k < LIMBS - 1; k++) begin
					opa_q[k] <= opa_q[k+1];
					opb_q[k] <= opb_q[k+1];
					w_q[k]   <= w_q[k+1];
				end
				opa_q[LIMBS-1] <= opa_q[0];
				opb_q[LIMBS-1] <= opb_q[0];
				w_q[LIMBS-1]   <= prep_w;
			end
			ST_CARRY: begin
				cy_q <= WIDE_W'(FOLD_LOW);
				for (int k = 0; k < LIMBS - 1; k++) w_q[k] <= w_q[k+1];
				if (cnt_q == 5'd15) begin
					// Bits at 2^255 and above come back in at limb 0 times 19.
					w_q[LIMBS-1] <= WIDE_W'(carry_v[14:0]);
					c_q <= WIDE_W'(FOLD_LOW) * (carry_v >> 15);
				end else begin
					w_q[LIMBS-1] <= WIDE_W'(carry_v[15:0]);
					c_q <= carry_v >> 16;
				end
			end
			ST_FINAL: begin
				// Trial value + 19 reaches bit 255 exactly when the value is p or above.
				cy_q <= fin_tv >> 16;
				for (int k = 0; k < LIMBS - 1; k++) begin
					w_q[k] <= w_q[k+1];
					t_q[k] <= t_q[k+1];
				end
				w_q[LIMBS-1] <= WIDE_W'(fin_we[15:0]);
				t_q[LIMBS-1] <= fin_tv[15:0];
				if (cnt_q == 5'd15) t_sel_q <= fin_tv[15];
			end
			ST_WB: begin
				for (int k = 0; k < LIMBS - 1; k++) begin
					w_q[k] <= w_q[k+1];
					t_q[k] <= t_q[k+1];
				end
				w_q[LIMBS-1] <= w_q[0];
				t_q[LIMBS-1] <= t_q[0];
				if (act_q == ACT_READ && cnt_q[3:0] == limb_q) rv_q <= r_limb;
			end
			ST_SWAP: begin
				if (cnt_q[4]) begin
					for (int k = 0; k < LIMBS - 1; k++) opa_q[k] <= opa_q[k+1];
					opa_q[LIMBS-1] <= opa_q[0];
				end else begin
					for (int k = 0; k < LIMBS - 1; k++) opb_q[k] <= opb_q[k+1];
					opb_q[LIMBS-1] <= opb_q[0];
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_rf_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_we && rf_re))
		else $error("register file read and write in the same cycle");

	a_scr_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(scr_we && scr_re))
		else $error("scratch read and write in the same cycle");

	a_inv_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && act_q == ACT_INV) |-> (bit_q <= INV_TOP_BIT))
		else $error("inversion exponent bit out of range");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the completion state");
`endif

endmodule

// ----- verif/testbench.sv -----
// Testbench for the GF(2^255-19) field unit: queued stream stimulus, scoreboard check.
`timescale 1ns / 1ps

module testbench;
	import cfa_pkg::*;

	typedef struct {
		act_t        action;
		logic [2:0]  dst_reg;
		logic [2:0]  src_a;
		logic [2:0]  src_b;
		logic [3:0]  limb_index;
		logic [15:0] limb_value;
		logic        swap_bit;
	} op_t;

	typedef struct {
		logic [15:0] read_value;
		act_t        done_action;
	} res_t;

	localparam logic [511:0] PRIME = (512'd1 << 255) - 512'd19;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	op_t         pending_ops[$];
	res_t        expected_results[$];
	logic [254:0] shadow_regs[8];
	int          errors;
	int          accepted;
	int          checked;
	int          act_count[8];
	int          hold_cycles;
	bit          hold_done;
	bit          in_xfer;
	bit          out_xfer;

	curve25519_field_alu uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [511:0] field_mul(logic [511:0] x, logic [511:0] y);
		logic [511:0] prod;
		prod = x * y;
		return prod % PRIME;
	endfunction

	// Applies one operation to the shadow register file and returns the read value.
	function automatic logic [15:0] field_apply(op_t op);
		logic [511:0] a;
		logic [511:0] b;
		logic [511:0] acc;
		logic [511:0] canon;
		logic [15:0]  v;
		a = {257'd0, shadow_regs[op.src_a]};
		b = {257'd0, shadow_regs[op.src_b]};
		case (op.action)
			ACT_WRITE: begin
				v = op.limb_value;
				if (op.limb_index == 4'd15) begin
					v = v & TOP_LIMB_MASK;
					shadow_regs[op.dst_reg][254:240] = v[14:0];
				end else begin
					shadow_regs[op.dst_reg][op.limb_index*16 +: 16] = v;
				end
			end
			ACT_READ: begin
				canon = a % PRIME;
				return canon[op.limb_index*16 +: 16];
			end
			ACT_ADD: begin
				canon = (a + b) % PRIME;
				shadow_regs[op.dst_reg] = canon[254:0];
			end
			ACT_SUB: begin
				canon = (a + 2 * PRIME - b) % PRIME;
				shadow_regs[op.dst_reg] = canon[254:0];
			end
			ACT_MUL: begin
				canon = field_mul(a, b);
				shadow_regs[op.dst_reg] = canon[254:0];
			end
			ACT_INV: begin
				// Square-and-multiply over the exponent p-2, whose only clear bits are 2 and 4.
				acc = a % PRIME;
				for (int bitpos = 253; bitpos >= 0; bitpos--) begin
					acc = field_mul(acc, acc);
					if (bitpos != 2 && bitpos != 4) acc = field_mul(acc, a);
				end
				shadow_regs[op.dst_reg] = acc[254:0];
			end
			ACT_SWAP: begin
				if (op.swap_bit) begin
					shadow_regs[op.src_a] = b[254:0];
					shadow_regs[op.src_b] = a[254:0];
				end
			end
			default: ;
		endcase
		return 16'd0;
	endfunction

	function automatic op_t make_op(act_t action, int d, int a, int b, int limb,
			int value, bit swap);
		op_t op;
		op.action = action;
		op.dst_reg = d[2:0];
		op.src_a = a[2:0];
		op.src_b = b[2:0];
		op.limb_index = limb[3:0];
		op.limb_value = value[15:0];
		op.swap_bit = swap;
		return op;
	endfunction

	function automatic logic [15:0] random_limb();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFED;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_load(int r, bit near_prime);
		for (int k = 0; k < 16; k++) begin
			if (near_prime)
				pending_ops.push_back(make_op(ACT_WRITE, r, 0, 0, k,
					k == 0 ? 16'hFFED - $urandom_range(0, 1) + $urandom_range(0, 1) :
					16'hFFFF, 0));
			else
				pending_ops.push_back(make_op(ACT_WRITE, r, 0, 0, k, random_limb(), 0));
		end
	endtask

	task automatic queue_random();
		int  pick;
		op_t op;
		pick = $urandom_range(0, 99);
		op = make_op(ACT_NOP, $urandom_range(0, 7), $urandom_range(0, 7),
			$urandom_range(0, 7), $urandom_range(0, 15), random_limb(),
			1'($urandom_range(0, 1)));
		if (pick < 30) op.action = ACT_WRITE;
		else if (pick < 55) op.action = ACT_READ;
		else if (pick < 65) op.action = ACT_ADD;
		else if (pick < 75) op.action = ACT_SUB;
		else if (pick < 88) op.action = ACT_MUL;
		else if (pick < 97) op.action = ACT_SWAP;
		else op.action = ACT_NOP;
		pending_ops.push_back(op);
	endtask

	initial begin
		int inv_slots;
		// Directed part: extremes, every action and the special cases.
		pending_ops.push_back(make_op(ACT_READ, 0, 3, 0, 7, 0, 0));
		pending_ops.push_back(make_op(ACT_WRITE, 1, 0, 0, 0, 16'hFFFF, 0));
		pending_ops.push_back(make_op(ACT_WRITE, 1, 0, 0, 15, 16'hFFFF, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 1, 0, 15, 0, 0));
		pending_ops.push_back(make_op(ACT_ADD, 2, 1, 1, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_SUB, 3, 0, 1, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_MUL, 1, 1, 1, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 1, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_INV, 4, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_INV, 5, 2, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 5, 0, 3, 0, 0));
		pending_ops.push_back(make_op(ACT_SWAP, 0, 2, 2, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_SWAP, 0, 2, 3, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_SWAP, 0, 2, 3, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_READ, 0, 2, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_NOP, 7, 7, 7, 15, 16'hFFFF, 1));
		pending_ops.push_back(make_op(ACT_SUB, 6, 6, 6, 0, 0, 0));
		// A stored value of exactly p must read back as zero.
		pending_ops.push_back(make_op(ACT_WRITE, 7, 0, 0, 0, 16'hFFED, 0));
		for (int k = 1; k < 15; k++)
			pending_ops.push_back(make_op(ACT_WRITE, 7, 0, 0, k, 16'hFFFF, 0));
		pending_ops.push_back(make_op(ACT_WRITE, 7, 0, 0, 15, 16'h7FFF, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 7, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_READ, 0, 7, 0, 15, 0, 0));
		// Random part: register loads mixed with random actions, and at most four inversions.
		inv_slots = 4;
		while (pending_ops.size() < 1450) begin
			if ($urandom_range(0, 99) < 12) begin
				queue_load($urandom_range(0, 7), $urandom_range(0, 3) == 0);
			end else if (inv_slots > 0 && $urandom_range(0, 299) == 0) begin
				pending_ops.push_back(make_op(ACT_INV, $urandom_range(0, 7),
					$urandom_range(0, 7), 0, 0, 0, 0));
				inv_slots--;
			end else begin
				queue_random();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int phase_of(int n);
		if (n < 480) return 0;
		if (n < 960) return 1;
		return 2;
	endfunction

	// Transfers on both sides are seen at the rising edge; the next input item goes out at the falling edge.
	always @(posedge clk) begin
		in_xfer = s_tvalid && s_tready && arst_n;
		out_xfer = m_tvalid && m_tready && arst_n;
		if (in_xfer) begin
			op_t  op;
			res_t r;
			op.action = act_t'(s_tdata[2:0]);
			op.dst_reg = s_tdata[5:3];
			op.src_a = s_tdata[8:6];
			op.src_b = s_tdata[11:9];
			op.limb_index = s_tdata[15:12];
			op.limb_value = s_tdata[31:16];
			op.swap_bit = s_tdata[32];
			r.read_value = field_apply(op);
			r.done_action = op.action;
			expected_results.push_back(r);
			act_count[op.action]++;
			accepted++;
		end
		if (out_xfer) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation: m_tdata=%h", m_tdata);
				errors++;
			end else begin
				res_t r;
				r = expected_results.pop_front();
				if (m_tdata[15:0] !== r.read_value) begin
					$error("read_value expected %h actual %h", r.read_value, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[18:16] !== r.done_action) begin
					$error("done_action expected %0d actual %0d", r.done_action,
						m_tdata[18:16]);
					errors++;
				end
				checked++;
			end
		end
	end

	always @(negedge clk) begin
		int  idle_pct;
		bit  offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (s_tvalid && !in_xfer) begin
			s_tvalid <= 1'b1;
		end else begin
			idle_pct = phase_of(accepted) == 0 ? 35 : (phase_of(accepted) == 1 ? 63 : 0);
			offer = pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct;
			if (offer) begin
				op_t op;
				op = pending_ops.pop_front();
				s_tdata <= {7'd0, op.swap_bit, op.limb_value, op.limb_index, op.src_b,
					op.src_a, op.dst_reg, op.action};
			end
			s_tvalid <= offer;
		end
	end

	// Output side: random back-pressure plus one long hold-off to fill the block.
	always @(negedge clk) begin
		int idle_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (!hold_done && accepted >= 1000) begin
			hold_done = 1'b1;
			hold_cycles = 400;
			m_tready <= 1'b0;
		end else begin
			idle_pct = phase_of(accepted) == 0 ? 63 : (phase_of(accepted) == 1 ? 35 : 0);
			m_tready <= $urandom_range(0, 99) >= idle_pct;
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		accepted = 0;
		checked = 0;
		hold_cycles = 0;
		hold_done = 1'b0;
		in_xfer = 1'b0;
		out_xfer = 1'b0;
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		foreach (act_count[i]) act_count[i] = 0;
		@(posedge arst_n);
		do @(posedge clk);
		while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0);
		repeat (300) @(posedge clk);
		if (expected_results.size() > 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		$display("Ran %0d items, checked %0d results: %0d writes, %0d reads, %0d add, %0d sub,",
			accepted, checked, act_count[ACT_WRITE], act_count[ACT_READ],
			act_count[ACT_ADD], act_count[ACT_SUB]);
		$display("  %0d mul, %0d invert, %0d swap, %0d no-op; %0d mismatches.",
			act_count[ACT_MUL], act_count[ACT_INV], act_count[ACT_SWAP],
			act_count[ACT_NOP], errors);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#60ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/cfa_pkg.sv
rtl/core/cfa_ram.sv
rtl/core/curve25519_field_alu.sv
verif/testbench.sv
